/* sv/isl_pkg.sv */
// Shared types and codes for the indexed shift list.
// No dependencies; used by the interfaces, the RAM user and the top level.
package isl_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned CNT_O_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_UPDATE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         age;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
  } rec_t;

endpackage

/* sv/isl_req_if.sv */
// Request channel of the indexed shift list: one list operation per transaction.
// Depends on isl_pkg for field widths.
interface isl_req_if;
  logic                      valid;
  logic                      ready;
  logic [isl_pkg::OP_W-1:0]  operation;
  logic [isl_pkg::POS_W-1:0] position;
  logic signed [31:0]        student_id;
  logic [7:0]                student_age;
  logic [63:0]               name_low;
  logic [15:0]               name_high;

  modport source (output valid, operation, position, student_id, student_age, name_low,
                  name_high, input ready);
  modport sink   (input valid, operation, position, student_id, student_age, name_low,
                  name_high, output ready);
endinterface

/* sv/isl_rsp_if.sv */
// Response channel of the indexed shift list: one result per transaction.
// Depends on isl_pkg for field widths.
interface isl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [isl_pkg::ST_W-1:0]    status;
  logic signed [31:0]          out_id;
  logic [7:0]                  out_age;
  logic [63:0]                 out_name_low;
  logic [15:0]                 out_name_high;
  logic [isl_pkg::CNT_O_W-1:0] entry_count;

  modport source (output valid, status, out_id, out_age, out_name_low, out_name_high,
                  entry_count, input ready);
  modport sink   (input valid, status, out_id, out_age, out_name_low, out_name_high,
                  entry_count, output ready);
endinterface

/* sv/isl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/indexed_shift_list_core.sv */
// Indexed shift list: ordered record list held in one RAM, shifted entry by entry.
// Depends on isl_pkg, isl_req_if, isl_rsp_if and isl_ram.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        operation, position, record fields
//   rsp_o    out  valid/ready        status, returned record, entry_count
//
// Insert and delete move one entry per cycle through the single RAM port pair.
// Insert below the tail shifts entries up from the tail to the position, then writes;
// delete shifts the entries above the position down; read fetches one entry; the
// others skip the shift. ready returns in the cycle the result is registered.
// The RAM is not cleared by reset; only the entry count is.
// req_i.ready is low while an item is in work; a result waiting on rsp_o
// stalls only the next item's completion, not its acceptance.
module indexed_shift_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  isl_req_if.sink   req_i,
  isl_rsp_if.source rsp_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;
  localparam int unsigned RW   = $bits(isl_pkg::rec_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_WRITE,
    S_RESP
  } state_e;

  state_e           state_q;
  isl_pkg::op_e     op_q;
  logic [AW-1:0]    pos_q;
  isl_pkg::rec_t    rec_new_q;
  isl_pkg::rec_t    rec_res_q;
  isl_pkg::status_e status_q;
  logic [CW-1:0]    count_q;

  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    rd_last_q;
  logic             rd_down_q;
  logic             rd_active_q;
  logic             pend_q;
  logic [AW-1:0]    pend_addr_q;

  logic                          rsp_valid_q;
  isl_pkg::status_e              rsp_status_q;
  isl_pkg::rec_t                 rsp_rec_q;
  logic [isl_pkg::CNT_O_W-1:0]   rsp_count_q;

  logic             accept;
  isl_pkg::op_e     req_op;
  isl_pkg::status_e acc_status;
  logic             acc_ok;
  logic [CMPW-1:0]  pos_x;
  logic [CMPW-1:0]  cnt_x;
  logic             is_full;
  logic             is_empty;
  isl_pkg::rec_t    req_rec;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RW-1:0]    ram_wdata;
  logic [RW-1:0]    ram_rdata;
  isl_pkg::rec_t    rd_rec;
  logic             pend_hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_op      = isl_pkg::op_e'(req_i.operation);
  assign pos_x       = CMPW'(req_i.position);
  assign cnt_x       = CMPW'(count_q);
  assign is_full     = (count_q == CW'(CAPACITY));
  assign is_empty    = (count_q == '0);

  assign req_rec.id        = req_i.student_id;
  assign req_rec.age       = req_i.student_age;
  assign req_rec.name_low  = req_i.name_low;
  assign req_rec.name_high = req_i.name_high;

  // Insert checks the index before fullness; delete, read and update check emptiness first.
  always_comb begin
    acc_status = isl_pkg::ST_OK;
    case (req_op)
      isl_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          acc_status = isl_pkg::ST_BAD_INDEX;
        end else if (is_full) begin
          acc_status = isl_pkg::ST_FULL;
        end
      end
      isl_pkg::OP_DELETE, isl_pkg::OP_READ, isl_pkg::OP_UPDATE: begin
        if (is_empty) begin
          acc_status = isl_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          acc_status = isl_pkg::ST_BAD_INDEX;
        end
      end
      default: acc_status = isl_pkg::ST_OK;
    endcase
  end
  assign acc_ok = (acc_status == isl_pkg::ST_OK);

  // Delete and read capture the entry at the position instead of moving it.
  assign rd_rec   = isl_pkg::rec_t'(ram_rdata);
  assign pend_hit = !rd_down_q && (pend_addr_q == pos_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = RW'(rec_new_q);
    case (state_q)
      S_SHIFT: begin
        ram_we    = pend_q && !pend_hit;
        ram_waddr = rd_down_q ? pend_addr_q + AW'(1) : pend_addr_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      S_WRITE: begin
        ram_we = 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  isl_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_active_q  <= 1'b0;
      pend_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
      op_q         <= isl_pkg::OP_CLEAR;
      status_q     <= isl_pkg::ST_OK;
      rsp_status_q <= isl_pkg::ST_OK;
      rd_down_q    <= 1'b0;
    end else begin
      // drop the result once taken, unless the response state loads the next one
      if (rsp_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q        <= req_op;
            pos_q       <= AW'(req_i.position);
            rec_new_q   <= req_rec;
            rec_res_q   <= '0;
            status_q    <= acc_status;
            case (req_op)
              isl_pkg::OP_CLEAR: begin
                count_q <= '0;
                state_q <= S_RESP;
              end
              isl_pkg::OP_INSERT: begin
                if (!acc_ok) begin
                  state_q <= S_RESP;
                end else if (pos_x == cnt_x) begin
                  state_q <= S_WRITE;
                end else begin
                  // walk down from the tail, each entry moves up by one
                  rd_addr_q   <= AW'(count_q - CW'(1));
                  rd_last_q   <= AW'(req_i.position);
                  rd_down_q   <= 1'b1;
                  rd_active_q <= 1'b1;
                  state_q     <= S_SHIFT;
                end
              end
              isl_pkg::OP_DELETE: begin
                if (acc_ok) begin
                  rd_addr_q   <= AW'(req_i.position);
                  rd_last_q   <= AW'(count_q - CW'(1));
                  rd_down_q   <= 1'b0;
                  rd_active_q <= 1'b1;
                  state_q     <= S_SHIFT;
                end else begin
                  state_q <= S_RESP;
                end
              end
              isl_pkg::OP_READ: begin
                if (acc_ok) begin
                  rd_addr_q   <= AW'(req_i.position);
                  rd_last_q   <= AW'(req_i.position);
                  rd_down_q   <= 1'b0;
                  rd_active_q <= 1'b1;
                  state_q     <= S_SHIFT;
                end else begin
                  state_q <= S_RESP;
                end
              end
              isl_pkg::OP_UPDATE: begin
                if (acc_ok) begin
                  state_q <= S_WRITE;
                end else begin
                  state_q <= S_RESP;
                end
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_SHIFT: begin
          if (rd_active_q) begin
            pend_q      <= 1'b1;
            pend_addr_q <= rd_addr_q;
            if (rd_addr_q == rd_last_q) begin
              rd_active_q <= 1'b0;
            end else begin
              rd_addr_q <= rd_down_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
            end
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q && pend_hit) begin
            rec_res_q <= rd_rec;
          end
          // last read data lands this cycle: finish the pass
          if (pend_q && !rd_active_q) begin
            if (op_q == isl_pkg::OP_INSERT) begin
              state_q <= S_WRITE;
            end else begin
              state_q <= S_RESP;
              if (op_q == isl_pkg::OP_DELETE) begin
                count_q <= count_q - CW'(1);
              end
            end
          end
        end
        S_WRITE: begin
          if (op_q == isl_pkg::OP_INSERT) begin
            count_q <= count_q + CW'(1);
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_rec_q    <= rec_res_q;
            rsp_count_q  <= isl_pkg::CNT_O_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.out_id        = rsp_rec_q.id;
  assign rsp_o.out_age       = rsp_rec_q.age;
  assign rsp_o.out_name_low  = rsp_rec_q.name_low;
  assign rsp_o.out_name_high = rsp_rec_q.name_high;
  assign rsp_o.entry_count   = rsp_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != S_IDLE))
    else $error("RAM written while idle");

  a_rsp_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_RESP))
    else $error("response raised outside the response state");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (int'(ram_waddr) < int'(CAPACITY)))
    else $error("RAM write address beyond capacity");

endmodule
